// File: rtl/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

  // Field widths fixed by the item format.
  localparam int KIND_W  = 3;
  localparam int WORD_W  = 32;
  localparam int CAPW    = 5;
  localparam int COUNT_W = 5;

  // Default number of cells in the chain.
  localparam int DEPTH_DEFAULT = 16;

  // Capacity after reset, before clamping to the chain length.
  localparam int CAP_RESET = 16;

  // Configuration register indexes.
  localparam int REG_CAPACITY = 0;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_QUERY      = 3'd4
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                     accepted;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
    logic [COUNT_W-1:0]       entry_count;
  } out_item_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic              shift_in;   // push at the front: every entry moves one cell back
    logic              shift_out;  // pop at the front: every entry moves one cell forward
    logic              append;     // push at the back: the first free cell loads the word
    logic [WORD_W-1:0] value;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/cdq_cell.sv
`default_nettype none

module cdq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  wire                         clk,
  input  wire cdq_pkg::cell_ctl_t     ctl,
  input  wire [CW-1:0]                count,
  input  wire [cdq_pkg::WORD_W-1:0]   left_data,
  input  wire [cdq_pkg::WORD_W-1:0]   right_data,
  output logic [cdq_pkg::WORD_W-1:0]  data
);
  import cdq_pkg::*;

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;

  // The cell takes its front neighbor's entry on a front push, its back
  // neighbor's entry on a front pop, and the pushed word when it is the first
  // free cell on a back push. Otherwise it keeps its entry.
  always_comb begin
    data_nxt = data_r;
    priority if (ctl.shift_in) begin
      data_nxt = left_data;
    end else if (ctl.shift_out) begin
      data_nxt = right_data;
    end else if (ctl.append && (count == CW'(IDX))) begin
      data_nxt = ctl.value;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

// File: rtl/circular_deque_buffer.sv
// Double-ended queue of signed 32-bit words.
//
// Input channel (in_valid, in_ready, in_item): each item carries an operation
// kind and a word. Kinds are push front, push back, pop front, pop back and
// query. A push on a full queue or a pop on an empty one is refused and leaves
// the contents alone; unknown kinds are refused the same way.
// Result channel (out_valid, out_ready, out_item): exactly one result item per
// input item, in order, holding the success flag plus the front value, rear
// value, empty flag, full flag and entry count after the operation. Front and
// rear read as -1 when the queue is empty.
// The result is valid in the cycle after its item is accepted. Throughput is
// one item per cycle; every operation is one step of the cell chain, and the
// next item is taken in the same cycle that the pending result is taken.
// While the receiver stalls, the result register holds and in_ready stays
// low until the result leaves.
// The APB port holds the capacity register at address 0 (1..16, clamped to the
// chain length). Writing it empties the queue. After reset the queue is empty
// and the capacity is 16 or the chain length if that is smaller.
`default_nettype none

module circular_deque_buffer #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire cdq_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  wire                  out_ready,
  output cdq_pkg::out_item_t   out_item,
  input  wire                  cfg_psel,
  input  wire                  cfg_penable,
  input  wire                  cfg_pwrite,
  input  wire [2:0]            cfg_paddr,
  input  wire [31:0]           cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import cdq_pkg::*;

  // Count must hold the chain length itself; cell indexes only reach DEPTH-1.
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = (CW > CAPW) ? CW : CAPW;
  localparam int CAP_RST = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

  // ---------------------------------------------------------------------
  // Configuration port. The register index is the word address.
  // ---------------------------------------------------------------------
  logic            cfg_wr;
  logic [CAPW-1:0] cap_r;
  logic [CAPW-1:0] cap_raw;
  logic [CAPW-1:0] cap_clamped;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite
                  && (cfg_paddr[2] == 1'(REG_CAPACITY));

  // A written zero means one slot, and anything past the chain means all of it.
  assign cap_raw = cfg_pwdata[CAPW-1:0];
  always_comb begin
    priority if (cap_raw == '0) begin
      cap_clamped = CAPW'(1);
    end else if (CMPW'(cap_raw) > CMPW'(DEPTH)) begin
      cap_clamped = CAPW'(DEPTH);
    end else begin
      cap_clamped = cap_raw;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == 1'(REG_CAPACITY)) begin
      cfg_prdata = 32'(cap_r);
    end
  end

  // ---------------------------------------------------------------------
  // Queue state. The front entry always sits in cell 0 and entries fill the
  // cells in order, so the rear entry is in cell count-1. The rear value is
  // also kept in its own register so only a back pop has to look it up.
  // ---------------------------------------------------------------------
  logic [CW-1:0]     count_r, count_nxt;
  logic [WORD_W-1:0] rear_r, rear_nxt;
  logic              accepted_r, accepted_nxt;
  logic              out_valid_r;
  logic [WORD_W-1:0] cell_q [DEPTH];
  cell_ctl_t         ctl;
  logic              take;
  logic              full, empty;

  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  assign full  = (CMPW'(count_r) >= CMPW'(cap_r));
  assign empty = (count_r == '0);

  always_comb begin
    ctl          = '0;
    ctl.value    = in_item.value;
    count_nxt    = count_r;
    rear_nxt     = rear_r;
    accepted_nxt = 1'b0;
    unique case (in_item.kind)
      KIND_PUSH_FRONT: begin
        if (!full) begin
          ctl.shift_in = 1'b1;
          count_nxt    = count_r + CW'(1);
          accepted_nxt = 1'b1;
          // Into an empty queue the new word is also the rear.
          if (empty) begin
            rear_nxt = in_item.value;
          end
        end
      end
      KIND_PUSH_BACK: begin
        if (!full) begin
          ctl.append   = 1'b1;
          count_nxt    = count_r + CW'(1);
          rear_nxt     = in_item.value;
          accepted_nxt = 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (!empty) begin
          ctl.shift_out = 1'b1;
          count_nxt     = count_r - CW'(1);
          accepted_nxt  = 1'b1;
        end
      end
      KIND_POP_BACK: begin
        if (!empty) begin
          count_nxt    = count_r - CW'(1);
          accepted_nxt = 1'b1;
          // The entry in front of the old rear becomes the new rear.
          if (count_r > CW'(1)) begin
            rear_nxt = cell_q[IW'(count_r - CW'(2))];
          end
        end
      end
      KIND_QUERY: begin
        accepted_nxt = 1'b1;
      end
      default: begin
        accepted_nxt = 1'b0;
      end
    endcase
    if (!take) begin
      ctl.shift_in  = 1'b0;
      ctl.shift_out = 1'b0;
      ctl.append    = 1'b0;
    end
  end

  // The cell chain. Each cell sees its two neighbors; cell 0 takes the pushed
  // word on a front push and the last cell keeps its own entry on a front pop.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_d;
    logic [WORD_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = in_item.value;
    end else begin : g_mid
      assign left_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end
    cdq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CAPW'(CAP_RST);
      out_valid_r <= 1'b0;
      accepted_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        cap_r   <= cap_clamped;
        count_r <= '0;
      end else if (take) begin
        count_r <= count_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
        accepted_r  <= accepted_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The rear register is payload and needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      rear_r <= rear_nxt;
    end
  end

  // The result is read straight from the state registers. No item moves them
  // while a result waits, since none is taken until it leaves; a capacity write can.
  assign out_valid            = out_valid_r;
  assign out_item.accepted    = accepted_r;
  assign out_item.is_empty    = empty;
  assign out_item.is_full     = full;
  assign out_item.entry_count = COUNT_W'(count_r);
  assign out_item.front_value = empty ? '1 : cell_q[0];
  assign out_item.rear_value  = empty ? '1 : rear_r;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_count_le_cap : assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(count_r) <= CMPW'(cap_r))
    else $error("entry count exceeds capacity");

  a_cfg_clears : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (count_r == '0))
    else $error("capacity write did not empty the queue");

  a_push_front_shows : assert property (@(posedge clk) disable iff (!rst_n)
    (take && (in_item.kind == KIND_PUSH_FRONT) && !full)
      |=> (out_item.front_value == $past(in_item.value)) && out_item.accepted)
    else $error("front push not visible at the front");

  a_push_back_shows : assert property (@(posedge clk) disable iff (!rst_n)
    (take && (in_item.kind == KIND_PUSH_BACK) && !full)
      |=> (out_item.rear_value == $past(in_item.value)) && out_item.accepted)
    else $error("back push not visible at the rear");

endmodule

`default_nettype wire

// File: dv/tb_circular_deque_buffer.sv
`default_nettype none

module tb_circular_deque_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  // Byte addresses on the configuration port. The second one lies past the
  // only register and must be ignored by the block.
  localparam logic [2:0] ADDR_CAPACITY = 3'(4 * REG_CAPACITY);
  localparam logic [2:0] ADDR_BEYOND   = 3'(4 * (REG_CAPACITY + 1));

  // First operation code that the block does not define.
  localparam logic [KIND_W-1:0] KIND_FIRST_UNDEFINED = 3'd5;

  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 95;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_CHURN, MODE_NOISE} burst_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  circular_deque_buffer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the deque: a ring of slots with a head index pointing at
  // the front entry and a tail index pointing one past the rear entry.
  logic [WORD_W-1:0] ring_slots [DEPTH_DEFAULT];
  int unsigned       head_idx = 0;
  int unsigned       tail_idx = 0;
  int unsigned       live_count = 0;
  int unsigned       ring_cap = CAP_RESET;

  in_item_t  pending_items [$];   // items waiting to be offered to the block
  out_item_t expected_results [$]; // predicted results, oldest first

  bit in_taken = 1'b0;   // an item was accepted at the last rising edge
  bit quiet = 1'b0;      // when set, neither side inserts any gaps
  int send_gap = 0;
  int stall_left = 0;
  int items_queued = 0;
  int results_seen = 0;
  int mismatches = 0;
  int refused_ops = 0;
  int full_results = 0;
  int cap_settings = 1;

  function automatic int unsigned ring_next(int unsigned i);
    return (i + 1 >= ring_cap) ? 0 : i + 1;
  endfunction

  function automatic int unsigned ring_prev(int unsigned i);
    return (i == 0) ? ring_cap - 1 : i - 1;
  endfunction

  // Only the low five bits of a written capacity count; zero is taken as one
  // slot and anything past the ring length as the full ring.
  function automatic int unsigned clamp_capacity(logic [31:0] raw);
    int unsigned c;
    c = raw[CAPW-1:0];
    if (c < 1) c = 1;
    if (c > DEPTH_DEFAULT) c = DEPTH_DEFAULT;
    return c;
  endfunction

  // Applies one operation to the shadow deque and returns the result that the
  // block must give for it.
  function automatic out_item_t apply_deque_op(in_item_t op);
    out_item_t r;
    logic      full;
    logic      empty;
    r = '0;
    full = (live_count >= ring_cap);
    empty = (live_count == 0);
    case (op.kind)
      KIND_PUSH_FRONT: begin
        if (!full) begin
          head_idx = ring_prev(head_idx);
          ring_slots[head_idx] = op.value;
          live_count++;
          r.accepted = 1'b1;
        end
      end
      KIND_PUSH_BACK: begin
        if (!full) begin
          ring_slots[tail_idx] = op.value;
          tail_idx = ring_next(tail_idx);
          live_count++;
          r.accepted = 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (!empty) begin
          head_idx = ring_next(head_idx);
          live_count--;
          r.accepted = 1'b1;
        end
      end
      KIND_POP_BACK: begin
        if (!empty) begin
          tail_idx = ring_prev(tail_idx);
          live_count--;
          r.accepted = 1'b1;
        end
      end
      KIND_QUERY: r.accepted = 1'b1;
      default:    r.accepted = 1'b0;
    endcase
    if (live_count == 0) begin
      r.front_value = -1;
      r.rear_value = -1;
    end else begin
      r.front_value = ring_slots[head_idx];
      r.rear_value = ring_slots[ring_prev(tail_idx)];
    end
    r.is_empty = (live_count == 0);
    r.is_full = (live_count >= ring_cap);
    r.entry_count = live_count[COUNT_W-1:0];
    return r;
  endfunction

  // Gap length for either side: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Sender. A valid item is held until it is accepted; after that the next
  // item follows at once or after a random gap.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // Item still waiting for in_ready: keep valid and payload as they are.
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap--;
    end else if (pending_items.size() > 0) begin
      in_item <= pending_items.pop_front();
      in_valid <= 1'b1;
      send_gap = pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver. out_ready is high for a cycle and then drops for a random
  // stall, which is usually zero so long runs of back-to-back results happen.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Monitor. A result leaving at this edge always belongs to an item taken at
  // an earlier edge, so it is checked before the item taken now is predicted.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual %0h", $time, out_item);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          report_field("accepted", 32'(want.accepted), 32'(out_item.accepted));
          report_field("front_value", want.front_value, out_item.front_value);
          report_field("rear_value", want.rear_value, out_item.rear_value);
          report_field("is_empty", 32'(want.is_empty), 32'(out_item.is_empty));
          report_field("is_full", 32'(want.is_full), 32'(out_item.is_full));
          report_field("entry_count", 32'(want.entry_count), 32'(out_item.entry_count));
          if (!want.accepted) refused_ops++;
          if (want.is_full) full_results++;
        end
      end
      in_taken = in_valid && in_ready;
      if (in_taken) expected_results.push_back(apply_deque_op(in_item));
    end
  end

  task automatic queue_op(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] value);
    in_item_t it;
    it.kind = kind;
    it.value = value;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Blocks until every queued item has produced its result, and then waits on
  // idle so that any stray result would still be caught.
  task automatic wait_drained();
    while (results_seen < items_queued) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready. Only a write to
  // the capacity address changes the shadow deque, and it empties it.
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == ADDR_CAPACITY) begin
      ring_cap = clamp_capacity(data);
      head_idx = 0;
      tail_idx = 0;
      live_count = 0;
      cap_settings++;
    end
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'h7FFF_FFFF;
    if (r < 6) return 32'h8000_0000;
    if (r < 8) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(burst_mode_t mode);
    int       r;
    bit       side;
    r = $urandom_range(0, 99);
    side = $urandom_range(0, 1);
    case (mode)
      MODE_FILL: begin
        if (r < 85) return side ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        if (r < 95) return side ? KIND_POP_BACK : KIND_POP_FRONT;
        return KIND_QUERY;
      end
      MODE_DRAIN: begin
        if (r < 85) return side ? KIND_POP_BACK : KIND_POP_FRONT;
        if (r < 95) return side ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        return KIND_QUERY;
      end
      MODE_CHURN: begin
        if (r < 45) return side ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        if (r < 90) return side ? KIND_POP_BACK : KIND_POP_FRONT;
        return KIND_QUERY;
      end
      default: return 3'($urandom_range(0, 7));
    endcase
  endfunction

  // Random traffic in bursts. Fill bursts drive the deque into full and wrap
  // the indices, drain bursts empty it again, churn bursts rotate it around
  // the ring, and the rare noise bursts mix in undefined codes.
  task automatic queue_random_ops(int count);
    burst_mode_t mode;
    int          burst;
    int          r;
    while (count > 0) begin
      r = $urandom_range(0, 99);
      if (r < 30) mode = MODE_FILL;
      else if (r < 60) mode = MODE_DRAIN;
      else if (r < 90) mode = MODE_CHURN;
      else mode = MODE_NOISE;
      burst = $urandom_range(1, 2 * ring_cap + 2);
      if (burst > count) burst = count;
      repeat (burst) queue_op(pick_kind(mode), pick_word());
      count -= burst;
    end
  endtask

  initial begin
    logic [31:0] cap_plan [PHASES];
    int          half;

    // Capacity values for the random phases; the raw values 0, 31, 17 and one
    // with upper bits set check the clamping and the five-bit field.
    cap_plan = '{32'd2, 32'd16, 32'd0, 32'd31, 32'd17, 32'd3, 32'hFFFF_FFE5, 32'd8,
                 32'($urandom_range(1, 16))};

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset capacity: reading and popping an empty deque,
    // extreme words on both ends (including -1 held as a live value), the
    // undefined codes, and draining back past empty.
    queue_op(KIND_QUERY, '0);
    queue_op(KIND_POP_FRONT, '0);
    queue_op(KIND_POP_BACK, '1);
    queue_op(KIND_PUSH_BACK, 32'h7FFF_FFFF);
    queue_op(KIND_PUSH_FRONT, 32'h8000_0000);
    queue_op(KIND_PUSH_BACK, '1);
    queue_op(KIND_PUSH_FRONT, '0);
    queue_op(KIND_FIRST_UNDEFINED, 32'h5555_5555);
    queue_op(KIND_FIRST_UNDEFINED + 3'd1, 32'hAAAA_AAAA);
    queue_op(KIND_FIRST_UNDEFINED + 3'd2, '1);
    queue_op(KIND_QUERY, '1);
    queue_op(KIND_POP_FRONT, '0);
    queue_op(KIND_POP_BACK, '0);
    queue_op(KIND_POP_FRONT, '0);
    queue_op(KIND_POP_BACK, '0);
    queue_op(KIND_POP_BACK, '0);
    queue_op(KIND_PUSH_BACK, 32'h1234_5678);
    wait_drained();

    // A write past the register list must leave the deque untouched.
    write_reg(ADDR_BEYOND, 32'd4);
    queue_op(KIND_QUERY, '0);
    wait_drained();

    // A capacity of zero is taken as one slot: full after a single push.
    write_reg(ADDR_CAPACITY, 32'd0);
    queue_op(KIND_QUERY, '0);
    queue_op(KIND_PUSH_FRONT, 32'hDEAD_BEEF);
    queue_op(KIND_PUSH_BACK, 32'h0BAD_F00D);
    queue_op(KIND_PUSH_FRONT, 32'h0000_0001);
    queue_op(KIND_POP_BACK, '0);
    queue_op(KIND_POP_FRONT, '0);
    queue_op(KIND_PUSH_BACK, 32'hCAFE_0001);
    wait_drained();

    // Random phases. Each one starts with a capacity write while the deque is
    // usually not empty, so the clearing on write is exercised every time.
    for (int p = 0; p < PHASES; p++) begin
      quiet = (p % 4 == 1);
      write_reg(ADDR_CAPACITY, cap_plan[p]);
      if (p == PHASES / 2) begin
        // Stop the sender halfway and let every result come back before
        // sending the rest, without touching the configuration.
        half = PHASE_ITEMS / 2;
        queue_random_ops(half);
        wait_drained();
        queue_random_ops(PHASE_ITEMS - half);
      end else begin
        queue_random_ops(PHASE_ITEMS);
      end
      wait_drained();
    end

    $display("Checked %0d results under %0d capacity settings.", results_seen, cap_settings);
    $display("%0d operations were refused and %0d results reported a full deque.",
             refused_ops, full_results);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run with every gap and stall at
  // its longest.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still outstanding", items_queued - results_seen);
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
